// ----- src/cpts_pkg.sv -----
`timescale 1ns / 1ps
// Package for the counter priority task scheduler.
// Holds field widths, parameter defaults, request codes and task state codes.
package cpts_pkg;

    localparam int NUM_SLOTS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    localparam int ACTION_W   = 3;
    localparam int SLOT_IN_W  = 4;
    localparam int PRIO_IN_W  = 8;
    localparam int TASK_OUT_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_WAIT   = 3'd2,
        ACT_WAKE   = 3'd3,
        ACT_EXIT   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_WAITING = 2'd1,
        ST_EXITED  = 2'd2
    } t_task_state;

endpackage

// ----- src/cpts_mem.sv -----
`timescale 1ns / 1ps
// Slot memory holding priority and time-slice counter per task slot.
// One write port, one read port with registered read data; no dependencies.
module cpts_mem #(
    parameter int NUM_SLOTS = 16,
    parameter int CNT_W     = 8
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_waddr,
    input  logic [CNT_W-1:0]             i_wprio,
    input  logic [CNT_W-1:0]             i_wcnt,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_raddr,
    output logic [CNT_W-1:0]             o_rprio,
    output logic [CNT_W-1:0]             o_rcnt
);

    logic [2*CNT_W-1:0] r_mem [NUM_SLOTS];
    logic [2*CNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wprio, i_wcnt};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rprio = r_rdata[2*CNT_W-1:CNT_W];
    assign o_rcnt  = r_rdata[CNT_W-1:0];

endmodule

// ----- src/cpts_pick.sv -----
`timescale 1ns / 1ps
// Shared compare unit: tracks the largest counter seen during a slot sweep.
// Strict greater-than keeps the lowest slot on ties; no dependencies.
module cpts_pick #(
    parameter int NUM_SLOTS = 16,
    parameter int CNT_W     = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_en,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_idx,
    input  logic [CNT_W-1:0]             i_cnt,
    output logic [$clog2(NUM_SLOTS)-1:0] o_best_idx,
    output logic [CNT_W-1:0]             o_best_cnt
);

    logic [$clog2(NUM_SLOTS)-1:0] r_best_idx;
    logic [CNT_W-1:0]             r_best_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best_idx <= '0;
            r_best_cnt <= '0;
        end else if (i_en && (i_cnt > r_best_cnt)) begin
            r_best_idx <= i_idx;
            r_best_cnt <= i_cnt;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_cnt = r_best_cnt;

endmodule

// ----- src/counter_priority_task_scheduler.sv -----
`timescale 1ns / 1ps
// Top level of the counter priority task scheduler: sequencer, slot flags, result register.
// Uses cpts_pkg, cpts_mem and cpts_pick.
//
//   channel  | valid        | ready        | payload
//   ---------+--------------+--------------+------------------------------------------
//   request  | i_in_valid   | o_in_ready   | i_action, i_slot, i_priority_req
//   result   | o_out_valid  | i_out_ready  | o_current_task, o_switched, o_refilled
//
// Create, wake and unknown codes go straight to the result state; a tick without
// reschedule passes S_TICK first. A reschedule sweeps the slot memory one slot per
// cycle through the compare unit: wait and exit start it at once, a tick after S_TICK
// when the counter runs out; a refill sweep follows when no running task has counter left.
// Reset is synchronous, active low; it leaves only the idle slot in use.
// A request is taken while a result waits; the next result holds until the last is taken.
module counter_priority_task_scheduler #(
    parameter int NUM_SLOTS     = cpts_pkg::NUM_SLOTS_DEF,
    parameter int PRIORITY_BITS = cpts_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cpts_pkg::ACTION_W-1:0]   i_action,
    input  logic [cpts_pkg::SLOT_IN_W-1:0]  i_slot,
    input  logic [cpts_pkg::PRIO_IN_W-1:0]  i_priority_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cpts_pkg::TASK_OUT_W-1:0] o_current_task,
    output logic                            o_switched,
    output logic                            o_refilled
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_SCAN_CHK,
        S_REFILL,
        S_REFILL_CHK,
        S_FIN
    } t_state;

    t_state                           r_state, n_state;
    logic [SLOT_W-1:0]                r_cur, n_cur;
    logic [SLOT_W-1:0]                r_before, n_before;
    logic                             r_refill, n_refill;
    logic [SLOT_W-1:0]                r_idx, n_idx;
    logic                             r_issue, n_issue;
    logic                             r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0]                r_rd_idx, n_rd_idx;
    logic [NUM_SLOTS-1:0]             r_used, n_used;
    cpts_pkg::t_task_state            r_tstate [NUM_SLOTS];
    cpts_pkg::t_task_state            n_tstate [NUM_SLOTS];
    logic                             r_out_valid, n_out_valid;
    logic [cpts_pkg::TASK_OUT_W-1:0]  r_out_task, n_out_task;
    logic                             r_out_sw, n_out_sw;
    logic                             r_out_ref, n_out_ref;

    logic                             in_acc;
    logic                             slot_ok;
    logic [SLOT_W-1:0]                slot_idx;
    logic [PRIORITY_BITS-1:0]         prio_in;
    logic [PRIORITY_BITS-1:0]         tick_cnt;
    logic                             mem_we;
    logic [SLOT_W-1:0]                mem_waddr;
    logic [PRIORITY_BITS-1:0]         mem_wprio;
    logic [PRIORITY_BITS-1:0]         mem_wcnt;
    logic [SLOT_W-1:0]                mem_raddr;
    logic [PRIORITY_BITS-1:0]         rd_prio;
    logic [PRIORITY_BITS-1:0]         rd_cnt;
    logic                             sweep;
    logic                             eligible;
    logic                             pick_clear;
    logic                             pick_en;
    logic [PRIORITY_BITS-1:0]         pick_cnt;
    logic [SLOT_W-1:0]                best_idx;
    logic [PRIORITY_BITS-1:0]         best_cnt;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_ok    = (32'(i_slot) < NUM_SLOTS);
    assign slot_idx   = SLOT_W'(i_slot);
    assign prio_in    = PRIORITY_BITS'(i_priority_req);
    assign tick_cnt   = (r_cur == '0) ? '0 : rd_cnt;
    assign mem_raddr  = (r_state == S_IDLE) ? r_cur : r_idx;

    assign sweep      = (r_state == S_SCAN) || (r_state == S_REFILL);
    assign eligible   = r_used[r_rd_idx] && (r_tstate[r_rd_idx] == cpts_pkg::ST_RUNNING);
    assign pick_clear = (r_state == S_IDLE);
    assign pick_en    = sweep && r_rd_vld && eligible;
    assign pick_cnt   = (r_state == S_REFILL) ? rd_prio : rd_cnt;

    cpts_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .CNT_W     (PRIORITY_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wprio (mem_wprio),
        .i_wcnt  (mem_wcnt),
        .i_raddr (mem_raddr),
        .o_rprio (rd_prio),
        .o_rcnt  (rd_cnt)
    );

    cpts_pick #(
        .NUM_SLOTS (NUM_SLOTS),
        .CNT_W     (PRIORITY_BITS)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (pick_clear),
        .i_en       (pick_en),
        .i_idx      (r_rd_idx),
        .i_cnt      (pick_cnt),
        .o_best_idx (best_idx),
        .o_best_cnt (best_cnt)
    );

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_before    = r_before;
        n_refill    = r_refill;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_idx;
        n_used      = r_used;
        n_tstate    = r_tstate;
        n_out_valid = r_out_valid;
        n_out_task  = r_out_task;
        n_out_sw    = r_out_sw;
        n_out_ref   = r_out_ref;
        mem_we      = 1'b0;
        mem_waddr   = r_cur;
        mem_wprio   = '0;
        mem_wcnt    = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_before = r_cur;
                    n_refill = 1'b0;
                    n_state  = S_FIN;
                    case (i_action)
                        cpts_pkg::ACT_TICK: begin
                            n_state = S_TICK;
                        end
                        cpts_pkg::ACT_CREATE: begin
                            if (slot_ok && (slot_idx != '0)) begin
                                n_used[slot_idx]   = 1'b1;
                                n_tstate[slot_idx] = cpts_pkg::ST_RUNNING;
                                mem_we             = 1'b1;
                                mem_waddr          = slot_idx;
                                mem_wprio          = prio_in;
                            end
                        end
                        cpts_pkg::ACT_WAIT: begin
                            n_tstate[r_cur] = cpts_pkg::ST_WAITING;
                            n_state         = S_SCAN;
                            n_idx           = FIRST_SLOT;
                            n_issue         = 1'b1;
                        end
                        cpts_pkg::ACT_WAKE: begin
                            if (slot_ok && r_used[slot_idx]) begin
                                n_tstate[slot_idx] = cpts_pkg::ST_RUNNING;
                            end
                        end
                        cpts_pkg::ACT_EXIT: begin
                            n_tstate[r_cur] = cpts_pkg::ST_EXITED;
                            mem_we          = 1'b1;
                            n_state         = S_SCAN;
                            n_idx           = FIRST_SLOT;
                            n_issue         = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (tick_cnt == '0) begin
                    n_state = S_SCAN;
                    n_idx   = FIRST_SLOT;
                    n_issue = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wprio = rd_prio;
                    mem_wcnt  = tick_cnt - 1'b1;
                    if (tick_cnt == PRIORITY_BITS'(1)) begin
                        n_state = S_SCAN;
                        n_idx   = FIRST_SLOT;
                        n_issue = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN, S_REFILL: begin
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                    if (r_idx == LAST_SLOT) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if ((r_state == S_REFILL) && r_rd_vld && r_used[r_rd_idx]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_idx;
                    mem_wprio = rd_prio;
                    mem_wcnt  = rd_prio;
                end
                if (r_rd_vld && (r_rd_idx == LAST_SLOT)) begin
                    n_state = (r_state == S_SCAN) ? S_SCAN_CHK : S_REFILL_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (best_cnt != '0) begin
                    n_cur   = best_idx;
                    n_state = S_FIN;
                end else begin
                    n_refill = 1'b1;
                    n_state  = S_REFILL;
                    n_idx    = FIRST_SLOT;
                    n_issue  = 1'b1;
                end
            end
            S_REFILL_CHK: begin
                n_cur   = best_idx;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_task  = cpts_pkg::TASK_OUT_W'(r_cur);
                    n_out_sw    = (r_cur != r_before);
                    n_out_ref   = r_refill;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_used      <= NUM_SLOTS'(1);
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_tstate[i] <= cpts_pkg::ST_RUNNING;
            end
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_issue     <= n_issue;
            r_rd_vld    <= n_rd_vld;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_tstate    <= n_tstate;
        end
        r_before   <= n_before;
        r_refill   <= n_refill;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_out_task <= n_out_task;
        r_out_sw   <= n_out_sw;
        r_out_ref  <= n_out_ref;
    end

    assign o_out_valid    = r_out_valid;
    assign o_current_task = r_out_task;
    assign o_switched     = r_out_sw;
    assign o_refilled     = r_out_ref;

`ifndef NO_ASSERTIONS
    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < NUM_SLOTS)
        else $error("current slot out of range");

    a_best_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK || r_state == S_REFILL_CHK) |->
            ((best_idx != '0) == (best_cnt != '0)))
        else $error("pick index and counter disagree");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous request in flight");

    a_idle_slot_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[0])
        else $error("idle slot lost its used flag");
`endif

endmodule
